[rtl/pcedc_pkg.sv]
// Shared types, constants and sine table builder for the chain end distance check.
`default_nettype none

package pcedc_pkg;

   localparam int ANGLE_W = 16;
   localparam int COORD_W = 24;
   localparam int DIST_W  = 21;
   localparam int DSQ_W   = 41;
   localparam int RSP_W   = 48;

   localparam logic [ANGLE_W-1:0] HALF_TURN   = 16'h8000;
   localparam logic [DIST_W-1:0]  DIST_LOW_RESET  = 21'd0;
   localparam logic [DIST_W-1:0]  DIST_HIGH_RESET = 21'd1064960;
   localparam longint COORD_MAX = 64'd8388607;
   localparam longint DSQ_MAX   = 64'h1FF_FFFF_FFFF;

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] TAYLOR_DIV [1:8] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                                64'd110, 64'd156, 64'd210, 64'd272};

   typedef enum logic [0:0] {
      REG_DIST_LOW  = 1'b0,
      REG_DIST_HIGH = 1'b1
   } csr_index_type;

   // sin(j * (pi/2) / quarter), rounded to frac_bits fraction bits
   function automatic logic [31:0] quarter_sine(input int unsigned j,
                                                input int unsigned addr_bits,
                                                input int unsigned frac_bits);
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [63:0] sum;
      int                 n;
      x    = (64'(j) * HALF_PI_Q30 + (64'd1 << (addr_bits - 3))) >> (addr_bits - 2);
      x2   = (x * x) >> 30;
      term = x;
      sum  = $signed(x);
      for (n = 1; n <= 8; n++) begin
         term = ((term * x2) >> 30) / TAYLOR_DIV[n];
         if ((n & 1) != 0) begin
            sum = sum - $signed(term);
         end else begin
            sum = sum + $signed(term);
         end
      end
      if (sum < 0) begin
         sum = '0;
      end
      return 32'(($unsigned(sum) + (64'd1 << (29 - frac_bits))) >> (30 - frac_bits));
   endfunction

endpackage

`default_nettype wire

[rtl/planar_chain_end_distance_check_top.sv]
// Planar chain end distance check: heading and end-point accumulation with bounds test.
// Throughput: one angle per cycle; the stages hold only while the result register is full.
// Stages: heading add, quarter-wave table read, coordinate accumulate, square, sum and compare.
// Reset (synchronous): heading 0, end point (1,0), dist_low 0, dist_high 1064960, stages empty.
`default_nettype none

module planar_chain_end_distance_check_top #(
   parameter int MAX_SEGMENTS    = 64,
   parameter int FRAC_BITS       = 14,
   parameter int TABLE_ADDR_BITS = 10
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [pcedc_pkg::ANGLE_W-1:0]      req_tdata,   // bond_angle (signed)
   input  logic                               req_tlast,   // last_angle
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [pcedc_pkg::RSP_W-1:0]        rsp_tdata,   // accepted, dist_squared, zero pad
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  pcedc_pkg::csr_index_type           csr_index,
   input  logic [pcedc_pkg::DIST_W-1:0]       csr_data
);

   import pcedc_pkg::*;

   localparam int QUARTER  = 1 << (TABLE_ADDR_BITS - 2);
   localparam int QIDX_W   = TABLE_ADDR_BITS - 1;
   localparam int TAB_W    = FRAC_BITS + 2;
   localparam int SQ_W     = 2 * COORD_W - 2;
   localparam int SUM_W    = SQ_W + 1;
   localparam int DSQ2_W   = 2 * DIST_W;
   localparam int PAD_W    = RSP_W - DSQ_W - 1;
   localparam longint COORD_LIM_RAW = longint'(MAX_SEGMENTS + 1) << FRAC_BITS;
   localparam longint COORD_LIM = (COORD_LIM_RAW > COORD_MAX) ? COORD_MAX : COORD_LIM_RAW;
   localparam longint DSQ_LIM_RAW = COORD_LIM * COORD_LIM;
   localparam longint DSQ_LIM_L = (DSQ_LIM_RAW > DSQ_MAX) ? DSQ_MAX : DSQ_LIM_RAW;
   localparam logic signed [COORD_W-1:0] LIM_POS = COORD_W'(COORD_LIM);
   localparam logic signed [COORD_W-1:0] LIM_NEG = -LIM_POS;
   localparam logic signed [COORD_W-1:0] X_RESET = COORD_W'(longint'(1) << FRAC_BITS);
   localparam logic [DSQ_W-1:0] DSQ_LIM = DSQ_W'(DSQ_LIM_L);
   localparam logic [QIDX_W-1:0] QIDX_TOP = QIDX_W'(QUARTER);

   function automatic logic signed [COORD_W-1:0] sat_add(
      input logic signed [COORD_W-1:0] a,
      input logic signed [TAB_W-1:0]   b);
      logic signed [COORD_W:0] s;
      s = (COORD_W+1)'(a) + (COORD_W+1)'(b);
      if (s > (COORD_W+1)'(LIM_POS)) begin
         return LIM_POS;
      end else if (s < (COORD_W+1)'(LIM_NEG)) begin
         return LIM_NEG;
      end
      return s[COORD_W-1:0];
   endfunction

   // quarter-wave sine table
   logic [TAB_W-1:0] qtab [QUARTER+1];

   for (genvar k = 0; k <= QUARTER; k++) begin : g_qtab
      localparam logic [TAB_W-1:0] QV =
         TAB_W'(quarter_sine(k, TABLE_ADDR_BITS, FRAC_BITS));
      assign qtab[k] = QV;
   end

   logic [DIST_W-1:0]  dist_low_ff, dist_high_ff;
   logic [DSQ2_W-1:0]  lo2_ff, hi2_ff, lo2_in, hi2_in;
   logic [ANGLE_W-1:0] heading_ff, heading_in, h_sum;

   logic               v1_ff, last1_ff, sneg1_ff, cneg1_ff;
   logic [QIDX_W-1:0]  sidx1_ff, cidx1_ff;
   logic               sneg_in, cneg_in;
   logic [QIDX_W-1:0]  sidx_in, cidx_in;

   logic                      v2_ff, last2_ff;
   logic signed [TAB_W-1:0]   sin2_ff, cos2_ff, sin_in, cos_in;

   logic signed [COORD_W-1:0] x_ff, y_ff, x_in, y_in, xs, ys;
   logic                      v3_ff;
   logic signed [COORD_W-1:0] x3_ff, y3_ff;

   logic signed [2*COORD_W-1:0] xsq, ysq;
   logic                        v4_ff;
   logic [SQ_W-1:0]             xx4_ff, yy4_ff;

   logic [SUM_W-1:0]  dsq;
   logic              rsp_valid_ff, accepted_ff, accepted_in;
   logic [DSQ_W-1:0]  dsq_ff, dsq_in;

   logic rdy1, rdy2, rdy3, rdy4, rdy_o, accept, adv2;

   logic [TABLE_ADDR_BITS-1:0] addr;
   logic [1:0]                 qs, qc;
   logic [QIDX_W-1:0]          jj;

   // stage readiness
   assign rdy_o  = !rsp_valid_ff || rsp_tready;
   assign rdy4   = !v4_ff || rdy_o;
   assign rdy3   = !v3_ff || rdy4;
   assign rdy2   = !v2_ff || !last2_ff || rdy3;
   assign rdy1   = !v1_ff || rdy2;
   assign accept = req_tvalid && rdy1;
   assign adv2   = v2_ff && rdy2;

   assign req_tready = rdy1;
   assign csr_ready  = 1'b1;

   // configuration
   assign lo2_in = DSQ2_W'(dist_low_ff) * DSQ2_W'(dist_low_ff);
   assign hi2_in = DSQ2_W'(dist_high_ff) * DSQ2_W'(dist_high_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         dist_low_ff  <= DIST_LOW_RESET;
         dist_high_ff <= DIST_HIGH_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_DIST_LOW:  dist_low_ff  <= csr_data;
            REG_DIST_HIGH: dist_high_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      lo2_ff <= lo2_in;
      hi2_ff <= hi2_in;
   end

   // heading and table addresses
   assign h_sum      = heading_ff + req_tdata + HALF_TURN;
   assign heading_in = req_tlast ? '0 : h_sum;
   assign addr       = h_sum[ANGLE_W-1 -: TABLE_ADDR_BITS];
   assign qs         = addr[TABLE_ADDR_BITS-1 -: 2];
   assign qc         = qs + 2'd1;
   assign jj         = {1'b0, addr[TABLE_ADDR_BITS-3:0]};
   assign sidx_in    = qs[0] ? (QIDX_TOP - jj) : jj;
   assign sneg_in    = qs[1];
   assign cidx_in    = qc[0] ? (QIDX_TOP - jj) : jj;
   assign cneg_in    = qc[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         heading_ff <= '0;
         v1_ff      <= 1'b0;
      end else begin
         if (accept) begin
            heading_ff <= heading_in;
         end
         if (rdy1) begin
            v1_ff <= req_tvalid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         last1_ff <= req_tlast;
         sidx1_ff <= sidx_in;
         sneg1_ff <= sneg_in;
         cidx1_ff <= cidx_in;
         cneg1_ff <= cneg_in;
      end
   end

   // table read
   assign sin_in = sneg1_ff ? -$signed(qtab[sidx1_ff]) : $signed(qtab[sidx1_ff]);
   assign cos_in = cneg1_ff ? -$signed(qtab[cidx1_ff]) : $signed(qtab[cidx1_ff]);

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (rdy2) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy2) begin
         last2_ff <= last1_ff;
         sin2_ff  <= sin_in;
         cos2_ff  <= cos_in;
      end
   end

   // end-point accumulation
   assign xs   = sat_add(x_ff, cos2_ff);
   assign ys   = sat_add(y_ff, sin2_ff);
   assign x_in = last2_ff ? X_RESET : xs;
   assign y_in = last2_ff ? '0 : ys;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff  <= X_RESET;
         y_ff  <= '0;
         v3_ff <= 1'b0;
      end else begin
         if (adv2) begin
            x_ff <= x_in;
            y_ff <= y_in;
         end
         if (rdy3) begin
            v3_ff <= v2_ff && last2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy3) begin
         x3_ff <= xs;
         y3_ff <= ys;
      end
   end

   // squares
   assign xsq = x3_ff * x3_ff;
   assign ysq = y3_ff * y3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (rdy4) begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy4) begin
         xx4_ff <= xsq[SQ_W-1:0];
         yy4_ff <= ysq[SQ_W-1:0];
      end
   end

   // sum, bounds test, saturate
   assign dsq         = SUM_W'(xx4_ff) + SUM_W'(yy4_ff);
   assign accepted_in = (dsq >= SUM_W'(lo2_ff)) && (dsq <= SUM_W'(hi2_ff));
   assign dsq_in      = (dsq > SUM_W'(DSQ_LIM)) ? DSQ_LIM : dsq[DSQ_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rdy_o) begin
         rsp_valid_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_o) begin
         accepted_ff <= accepted_in;
         dsq_ff      <= dsq_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, dsq_ff, accepted_ff};

   a_chain_heading_clear: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> heading_ff == '0)
      else $error("heading not cleared after last angle");

   a_chain_point_clear: assert property (@(posedge clock) disable iff (reset)
      adv2 && last2_ff |=> (x_ff == X_RESET) && (y_ff == '0))
      else $error("end point not returned to start after last angle");

   a_square_stage_hold: assert property (@(posedge clock) disable iff (reset)
      v3_ff && !rdy4 |=> v3_ff && $stable(x3_ff) && $stable(y3_ff))
      else $error("end point stage lost while stalled");

   a_result_load: assert property (@(posedge clock) disable iff (reset)
      v4_ff && rdy_o |=> rsp_tvalid)
      else $error("squared distance not moved to result register");

endmodule

`default_nettype wire

[tb/chain_end_distance_monitor.sv]
`timescale 1ns / 100ps
// Monitor that predicts the end distance of each observed angle chain and checks every result.
module chain_end_distance_monitor #(
   parameter int MAX_SEGMENTS    = 64,
   parameter int FRAC_BITS       = 14,
   parameter int TABLE_ADDR_BITS = 10
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   input  logic [pcedc_pkg::ANGLE_W-1:0]      req_tdata,   // bond_angle (signed)
   input  logic                               req_tlast,   // last_angle
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic [pcedc_pkg::RSP_W-1:0]        rsp_tdata,   // accepted, dist_squared, zero pad
   input  logic                               csr_valid,
   input  logic                               csr_ready,
   input  pcedc_pkg::csr_index_type           csr_index,
   input  logic [pcedc_pkg::DIST_W-1:0]       csr_data,
   output int                                 fail_count,
   output int                                 pending_results
);
   import pcedc_pkg::*;

   localparam int TABLE_LEN   = 1 << TABLE_ADDR_BITS;
   localparam int QUARTER_LEN = TABLE_LEN / 4;
   localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;
   localparam longint LIM_RAW     = longint'(MAX_SEGMENTS + 1) << FRAC_BITS;
   localparam longint COORD_LIMIT = (LIM_RAW > 64'sd8388607) ? 64'sd8388607 : LIM_RAW;
   localparam longint DSQ_RAW     = COORD_LIMIT * COORD_LIMIT;
   localparam longint DSQ_LIMIT   = (DSQ_RAW > 64'sh1FF_FFFF_FFFF) ? 64'sh1FF_FFFF_FFFF : DSQ_RAW;

   typedef struct packed {
      logic             accepted;
      logic [DSQ_W-1:0] dist_squared;
   } chain_end_type;

   int                 sine_lut [TABLE_LEN];
   logic [ANGLE_W-1:0] heading;
   longint             end_x;
   longint             end_y;
   logic [DIST_W-1:0]  dist_low;
   logic [DIST_W-1:0]  dist_high;
   chain_end_type      expected_ends [$];

   function automatic int quarter_wave_sine(input longint unsigned j);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint          acc;
      x    = (j * QUARTER_TURN_Q30 + QUARTER_LEN / 2) / QUARTER_LEN;
      x2   = (x * x) >> 30;
      term = x;
      acc  = longint'(x);
      for (int n = 1; n <= 8; n++) begin
         term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
         if (n % 2 == 1) begin
            acc = acc - longint'(term);
         end else begin
            acc = acc + longint'(term);
         end
      end
      if (acc < 0) begin
         acc = 0;
      end
      return int'((longint'(acc) + (longint'(1) << (29 - FRAC_BITS))) >> (30 - FRAC_BITS));
   endfunction

   initial begin
      for (int k = 0; k < TABLE_LEN; k++) begin
         case (k / QUARTER_LEN)
            0: sine_lut[k] = quarter_wave_sine(k % QUARTER_LEN);
            1: sine_lut[k] = quarter_wave_sine(QUARTER_LEN - k % QUARTER_LEN);
            2: sine_lut[k] = -quarter_wave_sine(k % QUARTER_LEN);
            default: sine_lut[k] = -quarter_wave_sine(QUARTER_LEN - k % QUARTER_LEN);
         endcase
      end
   end

   function automatic longint clamp_coord(input longint v);
      if (v > COORD_LIMIT) begin
         return COORD_LIMIT;
      end
      if (v < -COORD_LIMIT) begin
         return -COORD_LIMIT;
      end
      return v;
   endfunction

   function automatic void restart_chain();
      heading = '0;
      end_x   = longint'(1) << FRAC_BITS;
      end_y   = 0;
   endfunction

   function automatic void advance_chain(input logic [ANGLE_W-1:0] angle, input logic last);
      int unsigned   addr;
      longint        dsq;
      longint        lo2;
      longint        hi2;
      chain_end_type end_item;
      heading = heading + angle + 16'h8000;
      addr    = heading >> (ANGLE_W - TABLE_ADDR_BITS);
      end_x   = clamp_coord(end_x + sine_lut[(addr + QUARTER_LEN) % TABLE_LEN]);
      end_y   = clamp_coord(end_y + sine_lut[addr % TABLE_LEN]);
      if (last) begin
         dsq = end_x * end_x + end_y * end_y;
         lo2 = longint'(dist_low) * longint'(dist_low);
         hi2 = longint'(dist_high) * longint'(dist_high);
         end_item.accepted     = (dsq >= lo2) && (dsq <= hi2);
         end_item.dist_squared = (dsq > DSQ_LIMIT) ? DSQ_W'(DSQ_LIMIT) : DSQ_W'(dsq);
         expected_ends.push_back(end_item);
         restart_chain();
      end
   endfunction

   always @(posedge clock) begin
      chain_end_type want;
      if (reset) begin
         dist_low  = 21'd0;
         dist_high = 21'd1064960;
         restart_chain();
         expected_ends.delete();
         fail_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_DIST_LOW:  dist_low  = csr_data;
               REG_DIST_HIGH: dist_high = csr_data;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            advance_chain(req_tdata, req_tlast);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_ends.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("%0t: unexpected result: accepted %0b dist_squared %0d",
                           $time, rsp_tdata[0], rsp_tdata[DSQ_W:1]);
               end
            end else begin
               want = expected_ends.pop_front();
               if (want.accepted !== rsp_tdata[0] ||
                   want.dist_squared !== rsp_tdata[DSQ_W:1]) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("%0t: mismatch: accepted exp %0b got %0b, dsq exp %0d got %0d",
                              $time, want.accepted, rsp_tdata[0],
                              want.dist_squared, rsp_tdata[DSQ_W:1]);
                  end
               end
            end
         end
      end
      pending_results <= expected_ends.size();
   end

endmodule

[tb/planar_chain_end_distance_check_top_tb.sv]
`timescale 1ns / 100ps
// Testbench top: drives angle chains and bound writes into the block and reports the verdict.
module planar_chain_end_distance_check_top_tb;
   import pcedc_pkg::*;

   localparam int PIPE_LATENCY = 4;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_ITEMS = 800;
   localparam logic [DIST_W-1:0]  DIST_FULL = '1;
   localparam logic [ANGLE_W-1:0] STRAIGHT  = 16'h8000;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [ANGLE_W-1:0]   req_tdata  = '0;   // bond_angle (signed)
   logic                 req_tlast  = 1'b0; // last_angle
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [RSP_W-1:0]     rsp_tdata;         // accepted, dist_squared, zero pad
   logic                 csr_valid  = 1'b0;
   logic                 csr_ready;
   csr_index_type        csr_index  = REG_DIST_LOW;
   logic [DIST_W-1:0]    csr_data   = '0;

   int          fail_count;
   int          pending_results;
   int          burst_left  = 0;
   int          sent_items  = 0;
   int          cycle_count = 0;
   int          ready_mode  = 0;
   int unsigned ready_left  = 0;

   always #5 clock = ~clock;

   planar_chain_end_distance_check_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   chain_end_distance_monitor monitor (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tlast       (req_tlast),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .fail_count      (fail_count),
      .pending_results (pending_results)
   );

   always @(posedge clock) begin
      if (ready_left == 0) begin
         ready_mode <= $urandom_range(0, 3);
         ready_left <= $urandom_range(50, 300);
      end else begin
         ready_left <= ready_left - 1;
      end
      case (ready_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 3) != 0);
         2: rsp_tready <= ($urandom_range(0, 3) == 0);
         default: rsp_tready <= (ready_left % 16 < 3);
      endcase
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic send_angle(input logic [ANGLE_W-1:0] angle, input logic last);
      int gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                                  : $urandom_range(1, 24);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= angle;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      burst_left--;
      sent_items++;
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 3) @(posedge clock);
   endtask

   task automatic write_bounds(input logic [DIST_W-1:0] lo, input logic [DIST_W-1:0] hi);
      csr_valid <= 1'b1;
      csr_index <= REG_DIST_LOW;
      csr_data  <= lo;
      do @(posedge clock); while (!csr_ready);
      csr_index <= REG_DIST_HIGH;
      csr_data  <= hi;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int                 phase;
      int                 kind;
      int                 len;
      int                 base;
      int                 goal;
      logic [ANGLE_W-1:0] angle;
      logic [DIST_W-1:0]  lo;
      logic [DIST_W-1:0]  hi;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_angle(16'h0000, 1'b1);
      send_angle(16'h8000, 1'b1);
      send_angle(16'h7FFF, 1'b1);
      send_angle(16'h4000, 1'b1);
      send_angle(16'hC000, 1'b1);
      send_angle(16'hFFFF, 1'b1);
      send_angle(16'h0001, 1'b1);
      send_angle(16'h7FFF, 1'b0);
      send_angle(16'h8000, 1'b1);
      send_angle(16'h5555, 1'b0);
      send_angle(16'hAAAA, 1'b0);
      send_angle(16'h2000, 1'b1);
      // straight run along +x until the end point clips
      repeat (68) send_angle(STRAIGHT, 1'b0);
      send_angle(STRAIGHT, 1'b1);
      drain_results();

      base  = sent_items;
      phase = 0;
      while (sent_items - base < RANDOM_ITEMS) begin
         case (phase)
            0: begin lo = '0;              hi = DIST_FULL;       end
            1: begin lo = '0;              hi = '0;              end
            2: begin lo = DIST_FULL;       hi = DIST_FULL;       end
            3: begin lo = 21'd81920;       hi = 21'd32768;       end
            4: begin lo = DIST_HIGH_RESET; hi = DIST_HIGH_RESET; end
            default: begin
               lo = DIST_W'($urandom_range(0, 163840));
               if ($urandom_range(0, 7) == 0) begin
                  hi = DIST_W'($urandom_range(0, lo));
               end else begin
                  hi = lo + DIST_W'($urandom_range(0, 98304));
               end
            end
         endcase
         write_bounds(lo, hi);

         goal = sent_items + $urandom_range(80, 160);
         while (sent_items < goal) begin
            kind = $urandom_range(0, 19);
            if (kind < 12) begin
               len = $urandom_range(1, 6);
            end else if (kind < 16) begin
               len = $urandom_range(1, 20);
            end else if (kind < 19) begin
               len = $urandom_range(60, 100);
            end else begin
               len = $urandom_range(1, 3);
            end
            for (int i = 0; i < len; i++) begin
               if (kind < 12) begin
                  angle = ANGLE_W'($urandom_range(0, 65535));
               end else if (kind < 16) begin
                  angle = STRAIGHT + ANGLE_W'($urandom_range(0, 4095)) - 16'd2048;
               end else if (kind < 19) begin
                  angle = (i == 0) ? ANGLE_W'($urandom_range(0, 65535)) : STRAIGHT;
               end else begin
                  case ($urandom_range(0, 3))
                     0: angle = 16'h8000;
                     1: angle = 16'h7FFF;
                     2: angle = 16'h0000;
                     default: angle = 16'hFFFF;
                  endcase
               end
               send_angle(angle, i == len - 1);
            end
            if ($urandom_range(0, 39) == 0) begin
               drain_results();
            end
         end
         drain_results();
         phase++;
      end

      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
